### sv/sti_pkg.sv
// Shared constants for the segment / triangle intersection pipeline.
package sti_pkg;
  localparam int FIELD_W     = 48;            // one packed x/y/z point
  localparam int LANE_W      = 16;            // lane pitch inside a point
  localparam int IN_TDATA_W  = 5 * FIELD_W;   // five points
  localparam int OUT_TDATA_W = 104;           // hit + three Q16.16 words, padded
  localparam int QUOT_BITS   = 41;            // quotient clamps at 2^40
endpackage

### sv/segment_triangle_intersect.sv
// Segment / triangle intersection: fully pipelined plane solve and same-side test.
// Usage
//   Input channel (in_*): one transfer carries a whole test, the triangle
//   vertices A, B, C and the segment end points, each 48 bits packed as
//   x[15:0], y[31:16], z[47:32], signed COORD_BITS values in the low bits.
//   Output channel (out_*): one transfer per test with the hit flag and the
//   intersection point in signed Q(32-FRAC_BITS).FRAC_BITS, saturated.
//   out_tuser flags a segment parallel to the plane (or a degenerate
//   triangle); such a transfer has hit and point all zero.
// Throughput and stages
//   One test per cycle sustained while out_tready is high. Fifty register stages
//   (input, three set-up, division entry with the overflow check, 41 quotient-bit
//   stages, then point, edge cross, dot partial and output).
// Reset
//   rst_n low clears every stage valid; nothing is held in flight.
// Back-pressure
//   Each stage moves when its successor is empty or moving, so bubbles
//   close up behind a stalled output and new tests are still taken until
//   the pipeline is full. A stall loses or repeats nothing.
module segment_triangle_intersect #(
  parameter int COORD_BITS = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // vertex_a[47:0], vertex_b[95:48], vertex_c[143:96],
  // line_start[191:144], line_end[239:192]
  input  logic [sti_pkg::IN_TDATA_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // hit[0], point_x[32:1], point_y[64:33], point_z[96:65], zero pad above
  output logic [sti_pkg::OUT_TDATA_W-1:0] out_tdata,
  // parallel[0]
  output logic                            out_tuser
);
  import sti_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int QB   = QUOT_BITS;
  localparam int DW   = C + 1;                  // coordinate difference
  localparam int NW   = 2 * C + 3;              // normal component
  localparam int NUMW = 3 * C + 6;              // num / den
  localparam int NL   = (NUMW + 1) / 2;         // low split of |num|
  localparam int NH   = NUMW - NL;
  localparam int PW   = DW + NUMW;              // |d| * |num|
  localparam int RW   = NUMW + QB + 1;          // division remainder
  localparam int VW   = QB + 2;                 // m0 + term before saturation
  localparam int BW   = 34;                     // pt - q * scale
  localparam int CW   = DW + BW + 1;            // edge cross component
  localparam int CL   = CW / 2;
  localparam int SNW  = NW + 1;                 // side normal (negated normal)
  localparam int LPW  = CL + 1 + SNW;
  localparam int HPW  = CW - CL + SNW;
  localparam int SW   = CW + SNW + 3;

  localparam int S_IN = 0;
  localparam int S_A  = 1;
  localparam int S_B  = 2;
  localparam int S_C  = 3;
  localparam int S_DV = 4;
  localparam int S_E  = S_DV + QB + 1;
  localparam int S_F  = S_E + 1;
  localparam int S_G  = S_F + 1;
  localparam int S_H  = S_G + 1;
  localparam int NS   = S_H + 1;

  typedef logic [2:0][C-1:0] pnt_t;

  typedef struct packed {
    logic [2:0][RW-1:0] rem;
    logic [2:0][QB-1:0] quo;
    logic [2:0]         ovf;
    logic [2:0]         neg;
    logic [NUMW-1:0]    den;
    logic               par;
    pnt_t               p1, p2, p3, m0;
    logic [2:0][NW-1:0] nrm;
  } dv_t;

  // ---------------- handshake chain ----------------
  logic [NS-1:0] vld_r;
  logic [NS-1:0] rdy;

  always_comb begin
    rdy[NS-1] = !vld_r[NS-1] || out_tready;
    for (int i = NS - 2; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  assign in_tready  = rdy[S_IN];
  assign out_tvalid = vld_r[S_H];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_tvalid;
      end
      for (int i = 1; i < NS; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // ---------------- input register ----------------
  pnt_t p1_0_r, p2_0_r, p3_0_r, m0_0_r, m1_0_r;

  always_ff @(posedge clk) begin
    if (rdy[S_IN]) begin
      for (int k = 0; k < 3; k++) begin
        p1_0_r[k] <= in_tdata[0*FIELD_W + k*LANE_W +: C];
        p2_0_r[k] <= in_tdata[1*FIELD_W + k*LANE_W +: C];
        p3_0_r[k] <= in_tdata[2*FIELD_W + k*LANE_W +: C];
        m0_0_r[k] <= in_tdata[3*FIELD_W + k*LANE_W +: C];
        m1_0_r[k] <= in_tdata[4*FIELD_W + k*LANE_W +: C];
      end
    end
  end

  // ---------------- stage A: edges and normal ----------------
  logic signed [DW-1:0] e1[3], e2[3];
  logic [2:0][NW-1:0]   nrm_a_nxt;
  logic [2:0][DW-1:0]   d_a_nxt, w_a_nxt;
  logic [2:0][NW-1:0]   nrm_a_r;
  logic [2:0][DW-1:0]   d_a_r, w_a_r;
  pnt_t                 p1_a_r, p2_a_r, p3_a_r, m0_a_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      e1[k]         = $signed(p2_0_r[k]) - $signed(p1_0_r[k]);
      e2[k]         = $signed(p3_0_r[k]) - $signed(p1_0_r[k]);
      d_a_nxt[k]    = DW'($signed(m1_0_r[k]) - $signed(m0_0_r[k]));
      w_a_nxt[k]    = DW'($signed(p1_0_r[k]) - $signed(m0_0_r[k]));
    end
    nrm_a_nxt[0] = NW'($signed(NW'(e1[1] * e2[2])) - $signed(NW'(e1[2] * e2[1])));
    nrm_a_nxt[1] = NW'($signed(NW'(e1[2] * e2[0])) - $signed(NW'(e1[0] * e2[2])));
    nrm_a_nxt[2] = NW'($signed(NW'(e1[0] * e2[1])) - $signed(NW'(e1[1] * e2[0])));
  end

  always_ff @(posedge clk) begin
    if (rdy[S_A]) begin
      nrm_a_r <= nrm_a_nxt;
      d_a_r   <= d_a_nxt;
      w_a_r   <= w_a_nxt;
      p1_a_r  <= p1_0_r;
      p2_a_r  <= p2_0_r;
      p3_a_r  <= p3_0_r;
      m0_a_r  <= m0_0_r;
    end
  end

  // ---------------- stage B: num and den ----------------
  logic signed [NUMW-1:0] num_b_nxt, den_b_nxt;
  logic signed [NUMW-1:0] tn[3], td[3];
  logic [NUMW-1:0]        num_b_r, den_b_r;
  logic [2:0][DW-1:0]     d_b_r;
  logic [2:0][NW-1:0]     nrm_b_r;
  pnt_t                   p1_b_r, p2_b_r, p3_b_r, m0_b_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tn[k] = $signed(nrm_a_r[k]) * $signed(w_a_r[k]);
      td[k] = $signed(nrm_a_r[k]) * $signed(d_a_r[k]);
    end
    num_b_nxt = tn[0] + tn[1] + tn[2];
    den_b_nxt = td[0] + td[1] + td[2];
  end

  always_ff @(posedge clk) begin
    if (rdy[S_B]) begin
      num_b_r <= num_b_nxt;
      den_b_r <= den_b_nxt;
      d_b_r   <= d_a_r;
      nrm_b_r <= nrm_a_r;
      p1_b_r  <= p1_a_r;
      p2_b_r  <= p2_a_r;
      p3_b_r  <= p3_a_r;
      m0_b_r  <= m0_a_r;
    end
  end

  // ---------------- stage C: magnitudes and split products ----------------
  logic [NUMW-1:0]          num_m, den_m;
  logic [DW-1:0]            dm[3];
  logic                     num_neg, den_neg;
  logic [2:0][DW+NL-1:0]    pl_c_nxt, pl_c_r;
  logic [2:0][DW+NH-1:0]    ph_c_nxt, ph_c_r;
  logic [2:0]               neg_c_nxt, neg_c_r;
  logic [NUMW-1:0]          den_c_r;
  logic                     par_c_r;
  logic [2:0][NW-1:0]       nrm_c_r;
  pnt_t                     p1_c_r, p2_c_r, p3_c_r, m0_c_r;

  always_comb begin
    num_neg = num_b_r[NUMW-1];
    den_neg = den_b_r[NUMW-1];
    num_m   = num_neg ? NUMW'(-num_b_r) : num_b_r;
    den_m   = den_neg ? NUMW'(-den_b_r) : den_b_r;
    for (int k = 0; k < 3; k++) begin
      dm[k]        = d_b_r[k][DW-1] ? DW'(-d_b_r[k]) : d_b_r[k];
      pl_c_nxt[k]  = dm[k] * num_m[NL-1:0];
      ph_c_nxt[k]  = dm[k] * num_m[NUMW-1:NL];
      neg_c_nxt[k] = d_b_r[k][DW-1] != (num_neg != den_neg);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_C]) begin
      pl_c_r  <= pl_c_nxt;
      ph_c_r  <= ph_c_nxt;
      neg_c_r <= neg_c_nxt;
      den_c_r <= den_m;
      par_c_r <= (den_b_r == '0);
      nrm_c_r <= nrm_b_r;
      p1_c_r  <= p1_b_r;
      p2_c_r  <= p2_b_r;
      p3_c_r  <= p3_b_r;
      m0_c_r  <= m0_b_r;
    end
  end

  // ---------------- division pipeline ----------------
  dv_t dv_r  [QB+1];
  dv_t dv_nxt[QB+1];

  // entry stage: scaled dividend and overflow check
  logic [PW-1:0] prod[3];
  logic [RW-1:0] top_lim;

  always_comb begin
    top_lim     = RW'(den_c_r) << QB;
    dv_nxt[0]   = dv_r[0];
    dv_nxt[0].den = den_c_r;
    dv_nxt[0].par = par_c_r;
    dv_nxt[0].neg = neg_c_r;
    dv_nxt[0].nrm = nrm_c_r;
    dv_nxt[0].p1  = p1_c_r;
    dv_nxt[0].p2  = p2_c_r;
    dv_nxt[0].p3  = p3_c_r;
    dv_nxt[0].m0  = m0_c_r;
    for (int k = 0; k < 3; k++) begin
      prod[k]           = (PW'(ph_c_r[k]) << NL) + PW'(pl_c_r[k]);
      dv_nxt[0].rem[k]  = RW'(prod[k]) << FRAC_BITS;
      dv_nxt[0].ovf[k]  = dv_nxt[0].rem[k] >= top_lim;
      dv_nxt[0].quo[k]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_DV]) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  // one quotient bit per stage, most significant first
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int B = QB - 1 - j;
    logic [RW-1:0] sub;

    always_comb begin
      sub         = RW'(dv_r[j].den) << B;
      dv_nxt[j+1] = dv_r[j];
      for (int k = 0; k < 3; k++) begin
        if (dv_r[j].rem[k] >= sub) begin
          dv_nxt[j+1].rem[k]    = dv_r[j].rem[k] - sub;
          dv_nxt[j+1].quo[k][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[S_DV+j+1]) begin
        dv_r[j+1] <= dv_nxt[j+1];
      end
    end
  end

  // ---------------- stage E: point, clamp and saturate ----------------
  localparam logic [QB-1:0] QLIM = QB'(1) << (QB - 1);
  localparam logic signed [VW-1:0] SMAX = VW'(32'sh7fff_ffff);
  localparam logic signed [VW-1:0] SMIN = ~SMAX;

  logic [QB-1:0]          qv[3];
  logic signed [VW-1:0]   term[3], sm[3], val[3];
  logic [2:0][31:0]       pt_e_nxt, pt_e_r;
  logic                   par_e_r;
  logic [2:0][NW-1:0]     nrm_e_r;
  pnt_t                   p1_e_r, p2_e_r, p3_e_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      qv[k]   = (dv_r[QB].ovf[k] || dv_r[QB].quo[k] > QLIM) ? QLIM : dv_r[QB].quo[k];
      term[k] = dv_r[QB].neg[k] ? -$signed(VW'(qv[k])) : $signed(VW'(qv[k]));
      sm[k]   = $signed(dv_r[QB].m0[k]);
      val[k]  = (sm[k] <<< FRAC_BITS) + term[k];
      if (dv_r[QB].par) begin
        pt_e_nxt[k] = '0;
      end else if (val[k] > SMAX) begin
        pt_e_nxt[k] = 32'h7fff_ffff;
      end else if (val[k] < SMIN) begin
        pt_e_nxt[k] = 32'h8000_0000;
      end else begin
        pt_e_nxt[k] = val[k][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_E]) begin
      pt_e_r  <= pt_e_nxt;
      par_e_r <= dv_r[QB].par;
      nrm_e_r <= dv_r[QB].nrm;
      p1_e_r  <= dv_r[QB].p1;
      p2_e_r  <= dv_r[QB].p2;
      p3_e_r  <= dv_r[QB].p3;
    end
  end

  // ---------------- stage F: edge cross products ----------------
  // edges P1->P3, P3->P2, P2->P1
  pnt_t                 ep[3], eq[3];
  logic signed [DW-1:0] ea[3][3];
  logic signed [BW-1:0] eb[3][3], qs;
  logic [2:0][2:0][CW-1:0] c_f_nxt, c_f_r;
  logic [2:0][SNW-1:0]  sn_f_r;
  logic                 par_f_r;

  always_comb begin
    ep[0] = p1_e_r; eq[0] = p3_e_r;
    ep[1] = p3_e_r; eq[1] = p2_e_r;
    ep[2] = p2_e_r; eq[2] = p1_e_r;
    qs    = '0;
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        ea[e][k] = $signed(eq[e][k]) - $signed(ep[e][k]);
        qs       = $signed(eq[e][k]);
        eb[e][k] = $signed(pt_e_r[k]) - (qs <<< FRAC_BITS);
      end
      c_f_nxt[e][0] = CW'($signed(CW'(ea[e][1] * eb[e][2])) - $signed(CW'(ea[e][2] * eb[e][1])));
      c_f_nxt[e][1] = CW'($signed(CW'(ea[e][2] * eb[e][0])) - $signed(CW'(ea[e][0] * eb[e][2])));
      c_f_nxt[e][2] = CW'($signed(CW'(ea[e][0] * eb[e][1])) - $signed(CW'(ea[e][1] * eb[e][0])));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_F]) begin
      c_f_r   <= c_f_nxt;
      par_f_r <= par_e_r;
      for (int k = 0; k < 3; k++) begin
        sn_f_r[k] <= SNW'(-$signed(SNW'($signed(nrm_e_r[k]))));
      end
    end
  end

  // ---------------- stage G: split dot-product partials ----------------
  logic [2:0][2:0][LPW-1:0] lo_g_nxt, lo_g_r;
  logic [2:0][2:0][HPW-1:0] hi_g_nxt, hi_g_r;
  logic                     par_g_r;
  logic [31:0]              pt_f_r[3], pt_g_r[3];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      for (int k = 0; k < 3; k++) begin
        lo_g_nxt[e][k] = LPW'($signed({1'b0, c_f_r[e][k][CL-1:0]}) * $signed(sn_f_r[k]));
        hi_g_nxt[e][k] = HPW'($signed(c_f_r[e][k][CW-1:CL]) * $signed(sn_f_r[k]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[S_F]) begin
      for (int k = 0; k < 3; k++) pt_f_r[k] <= pt_e_r[k];
    end
    if (rdy[S_G]) begin
      lo_g_r  <= lo_g_nxt;
      hi_g_r  <= hi_g_nxt;
      par_g_r <= par_f_r;
      for (int k = 0; k < 3; k++) pt_g_r[k] <= pt_f_r[k];
    end
  end

  // ---------------- stage H: sums, sign tests, output register ----------------
  logic signed [SW-1:0] hs[3], ls[3], tot[3];
  logic [2:0]           lft;
  logic                 hit_h;
  logic [OUT_TDATA_W-1:0] tdata_nxt, tdata_r;
  logic                 tuser_r;

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      hs[e]  = $signed(hi_g_r[e][0]) + $signed(hi_g_r[e][1]) + $signed(hi_g_r[e][2]);
      ls[e]  = $signed(lo_g_r[e][0]) + $signed(lo_g_r[e][1]) + $signed(lo_g_r[e][2]);
      tot[e] = (hs[e] <<< CL) + ls[e];
      lft[e] = tot[e] > 0;
    end
    hit_h     = !par_g_r && (lft[1] == lft[0]) && (lft[2] == lft[0]);
    tdata_nxt = '0;
    tdata_nxt[0]     = hit_h;
    tdata_nxt[32:1]  = pt_g_r[0];
    tdata_nxt[64:33] = pt_g_r[1];
    tdata_nxt[96:65] = pt_g_r[2];
  end

  always_ff @(posedge clk) begin
    if (rdy[S_H]) begin
      tdata_r <= tdata_nxt;
      tuser_r <= par_g_r;
    end
  end

  assign out_tdata = tdata_r;
  assign out_tuser = tuser_r;

endmodule

### sv/sti_chk.sv
// Port-level checker for the intersection pipeline, bound to the top level.
module sti_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sti_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);
  import sti_pkg::*;

  // nothing comes out in the cycle after reset
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid straight after reset");

  // a held result keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // a parallel result carries no hit and a zero point
  a_par_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("parallel result not zero");

  // a free output end means the input side is open
  a_open: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked with output free");
endmodule

bind segment_triangle_intersect sti_chk u_sti_chk (.*);

### tb/segment_triangle_intersect_test.sv
// Self-checking testbench for the segment / triangle intersection pipeline.
module segment_triangle_intersect_test;
  timeunit 1ns;
  timeprecision 1ps;
  import sti_pkg::*;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int IDLE_PCT   = 38;

  typedef longint vec3_t [3];
  typedef logic signed [127:0] wide_t;

  // one expected outcome of a test
  typedef struct {
    bit          hit;
    bit          parallel;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } isect_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // vertex_a, vertex_b, vertex_c, line_start, line_end (lowest first)
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  // hit, point_x, point_y, point_z (lowest first), zero pad
  logic [OUT_TDATA_W-1:0] out_tdata;
  // parallel
  logic out_tuser;

  logic [IN_TDATA_W-1:0] test_queue[$];    // tests not yet offered
  isect_t                isect_queue[$];   // outcomes awaiting their transfer
  int                    errors = 0;
  int                    cycle = 0;
  bit                    stim_done = 1'b0;

  segment_triangle_intersect #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  // low COORD_BITS of the lane, sign-extended; bits above are ignored
  function automatic longint lane_coord(logic [47:0] pnt, int lane);
    logic [15:0] raw;
    longint      v;
    raw = pnt[16*lane +: 16];
    v   = longint'({48'd0, raw}) & ((longint'(1) << COORD_BITS) - 1);
    if (v[COORD_BITS-1]) v -= longint'(1) << COORD_BITS;
    return v;
  endfunction

  function automatic vec3_t cross3(vec3_t a, vec3_t b);
    vec3_t c;
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
    return c;
  endfunction

  // edge p->q: ((q - p) x (pt - q)) . n > 0, pt in fixed point
  function automatic bit left_of_edge(vec3_t p, vec3_t q, vec3_t pt, vec3_t n);
    vec3_t a, b, c;
    wide_t acc, wc, wn;
    acc = '0;
    for (int k = 0; k < 3; k++) begin
      a[k] = q[k] - p[k];
      b[k] = pt[k] - q[k] * (longint'(1) << FRAC_BITS);
    end
    c = cross3(a, b);
    for (int k = 0; k < 3; k++) begin
      wc = c[k];
      wn = n[k];
      acc = acc + wc * wn;
    end
    return acc > 0;
  endfunction

  function automatic isect_t solve_intersection(logic [IN_TDATA_W-1:0] td);
    vec3_t p1, p2, p3, m0, m1, e1, e2, nrm, d, pt, u, v, sn;
    longint num, den, term, val;
    logic [127:0] numer, quot, mag_num, mag_den, mag_d;
    isect_t r;
    bit l0, l1, l2;
    num = 0;
    den = 0;
    r = '{hit: 1'b0, parallel: 1'b0, px: '0, py: '0, pz: '0};
    for (int k = 0; k < 3; k++) begin
      p1[k] = lane_coord(td[47:0], k);
      p2[k] = lane_coord(td[95:48], k);
      p3[k] = lane_coord(td[143:96], k);
      m0[k] = lane_coord(td[191:144], k);
      m1[k] = lane_coord(td[239:192], k);
      e1[k] = p2[k] - p1[k];
      e2[k] = p3[k] - p1[k];
      d[k]  = m1[k] - m0[k];
    end
    nrm = cross3(e1, e2);
    for (int k = 0; k < 3; k++) begin
      num += nrm[k] * (p1[k] - m0[k]);
      den += nrm[k] * d[k];
    end
    if (den == 0) begin
      r.parallel = 1'b1;
      return r;
    end
    mag_num = (num < 0) ? -num : num;
    mag_den = (den < 0) ? -den : den;
    for (int k = 0; k < 3; k++) begin
      mag_d = (d[k] < 0) ? -d[k] : d[k];
      numer = (mag_d * mag_num) << FRAC_BITS;
      quot  = numer / mag_den;
      if (quot > (128'd1 << 40)) quot = 128'd1 << 40;
      term = longint'(quot[63:0]);
      if ((d[k] < 0) != ((num < 0) != (den < 0))) term = -term;
      val = m0[k] * (longint'(1) << FRAC_BITS) + term;
      if (val > 64'sd2147483647) val = 64'sd2147483647;
      if (val < -64'sd2147483648) val = -64'sd2147483648;
      pt[k] = val;
    end
    r.px = pt[0][31:0];
    r.py = pt[1][31:0];
    r.pz = pt[2][31:0];
    for (int k = 0; k < 3; k++) begin
      u[k] = p3[k] - p1[k];
      v[k] = p2[k] - p3[k];
    end
    sn = cross3(u, v);
    l0 = left_of_edge(p1, p3, pt, sn);
    l1 = left_of_edge(p3, p2, pt, sn);
    l2 = left_of_edge(p2, p1, pt, sn);
    r.hit = (l1 == l0) && (l2 == l0);
    return r;
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic logic [47:0] point(int x, int y, int z);
    return {z[15:0], y[15:0], x[15:0]};
  endfunction

  task automatic add_test(logic [47:0] a, logic [47:0] b, logic [47:0] c,
                          logic [47:0] s, logic [47:0] e);
    test_queue.push_back({e, s, c, b, a});
  endtask

  function automatic int srand(int span);
    return $urandom_range(2 * span) - span;
  endfunction

  // segment through a point near the triangle, usually inside it
  task automatic add_crossing_test();
    int ax, ay, az, bx, by, bz, cx, cy, cz, wa, wb, wc, ws, tx, ty, tz, dx, dy, dz, k;
    ax = srand(2000); ay = srand(2000); az = srand(2000);
    bx = srand(2000); by = srand(2000); bz = srand(2000);
    cx = srand(2000); cy = srand(2000); cz = srand(2000);
    wa = $urandom_range(12) - 1;
    wb = $urandom_range(12) - 1;
    wc = $urandom_range(12) - 1;
    ws = wa + wb + wc;
    if (ws <= 0) ws = 1;
    tx = (ax * wa + bx * wb + cx * wc) / ws;
    ty = (ay * wa + by * wb + cy * wc) / ws;
    tz = (az * wa + bz * wb + cz * wc) / ws;
    dx = srand(3000); dy = srand(3000); dz = srand(3000);
    k  = $urandom_range(3);
    if ($urandom_range(9) == 0) begin
      // parallel: segment along an edge direction
      add_test(point(ax, ay, az), point(bx, by, bz), point(cx, cy, cz),
               point(tx, ty, tz), point(tx + bx - ax, ty + by - ay, tz + bz - az));
    end else begin
      add_test(point(ax, ay, az), point(bx, by, bz), point(cx, cy, cz),
               point(tx + dx, ty + dy, tz + dz),
               point(tx - dx * k, ty - dy * k, tz - dz * k));
    end
  endtask

  initial begin
    // all zero: degenerate, parallel
    add_test('0, '0, '0, '0, '0);
    // all ones / all extremes
    add_test('1, '1, '1, '1, '1);
    add_test(point(32767, 32767, 32767), point(-32768, -32768, -32768),
             point(32767, -32768, 0), point(-32768, 32767, 32767),
             point(32767, 32767, -32768));
    add_test(point(-32768, 0, 0), point(32767, 0, 0), point(0, 32767, 0),
             point(0, 100, -32768), point(0, 100, 32767));
    // plain hit through the middle, and a clean miss
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(20, 20, 50), point(20, 20, -50));
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(200, 200, 50), point(200, 200, -50));
    // segment exactly on a vertex and on an edge
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(0, 0, 10), point(0, 0, -10));
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(50, 0, 10), point(50, 0, -10));
    // parallel segment, and a segment lying in the plane
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(10, 10, 5), point(90, 10, 5));
    add_test(point(0, 0, 0), point(100, 0, 0), point(0, 100, 0),
             point(10, 10, 0), point(90, 30, 0));
    // degenerate triangle (collinear vertices)
    add_test(point(0, 0, 0), point(10, 10, 10), point(20, 20, 20),
             point(5, 0, 3), point(-5, 7, 9));
    // nearly parallel: far intersection, saturation and quotient clamp
    add_test(point(-32768, -32768, 0), point(32767, -32768, 1),
             point(0, 32767, 0), point(32767, 32767, 32767),
             point(-32768, 32767, 32767));
    add_test(point(0, 0, 0), point(32767, 0, 1), point(0, 32767, 0),
             point(-32768, 0, 1), point(32767, 0, 0));
    // fractional intersection, negative side
    add_test(point(-7, -3, 1), point(5, -9, 2), point(1, 11, -4),
             point(-3, 2, 7), point(1, -1, -6));
    add_test(point(100, 100, 100), point(-100, 100, 100), point(0, -100, 100),
             point(1, 2, 3), point(1, 2, 300));
    for (int i = 0; i < 500; i++) begin
      case ($urandom_range(9))
        0: test_queue.push_back(IN_TDATA_W'({$urandom, $urandom, $urandom, $urandom,
                                             $urandom, $urandom, $urandom, $urandom}));
        1: add_test(point(srand(32767), srand(32767), srand(32767)),
                    point(srand(32767), srand(32767), srand(32767)),
                    point(srand(32767), srand(32767), srand(32767)),
                    point(srand(32767), srand(32767), srand(32767)),
                    point(srand(32767), srand(32767), srand(32767)));
        default: add_crossing_test();
      endcase
    end
    stim_done = 1'b1;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        isect_queue.push_back(solve_intersection(in_tdata));
      // hold until taken; otherwise maybe offer the next test
      if (!in_tvalid || in_tready) begin
        if (test_queue.size() != 0 &&
            ((cycle > 300 && cycle < 600) || $urandom_range(99) >= IDLE_PCT)) begin
          in_tdata  <= test_queue.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    isect_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (isect_queue.size() == 0) begin
          report("unexpected transfer", out_tdata[31:0], 32'd0);
        end else begin
          want = isect_queue.pop_front();
          if (out_tdata[0] !== want.hit) report("hit", out_tdata[0], want.hit);
          if (out_tuser !== want.parallel) report("parallel", out_tuser, want.parallel);
          if (out_tdata[32:1] !== want.px) report("point_x", out_tdata[32:1], want.px);
          if (out_tdata[64:33] !== want.py) report("point_y", out_tdata[64:33], want.py);
          if (out_tdata[96:65] !== want.pz) report("point_z", out_tdata[96:65], want.pz);
        end
      end
      out_tready <= (cycle > 300 && cycle < 600) || $urandom_range(99) >= IDLE_PCT;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    wait (stim_done);
    while (test_queue.size() != 0 || in_tvalid) @(posedge clk);
    while (isect_queue.size() != 0) @(posedge clk);
    // anything surplus would show up within the pipeline latency
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

  initial begin
    #1ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
